// ===== sv/at_pkg.sv =====
// alarm table package: sizes, codes, the token that walks the slot chain
// no dependencies; used by at_cell, at_history, alarm_table and the bench

package at_pkg;

  localparam int ALARM_SLOTS   = 16;
  localparam int HISTORY_DEPTH = 16;
  localparam int ID_BITS       = 16;

  localparam int SLOT_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int HIST_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(ALARM_SLOTS + 1);

  localparam logic [2:0] SEV_MAX = 3'd4;

  typedef enum logic [1:0] {
    MODE_RAISE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    RS_OK   = 2'd0,
    RS_BAD  = 2'd1,
    RS_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_REFRESH = 2'd1,
    OP_NEW     = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic {
    PH_SEARCH = 1'b0,
    PH_APPLY  = 1'b1
  } phase_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SEARCH = 2'd1,
    S_APPLY  = 2'd2,
    S_DONE   = 2'd3
  } state_e;

  // token handed from cell to cell, one hop per cycle
  typedef struct packed {
    logic               vld;
    phase_e             phase;
    logic [ID_BITS-1:0] id;
    logic [2:0]         sev;
    op_e                op;
    logic [SLOT_W-1:0]  tgt;
    logic               hit;
    logic [SLOT_W-1:0]  hit_idx;
    logic               free_found;
    logic [SLOT_W-1:0]  free_idx;
    logic [CNT_W-1:0]   count;
    logic [2:0]         maxsev;
    logic [31:0]        raises;
  } tok_t;

  function automatic logic [ID_BITS-1:0] id_of(input logic [15:0] raw_id);
    logic [31:0] w;
    w = 32'(raw_id);
    return w[ID_BITS-1:0];
  endfunction

endpackage

// ===== sv/at_if.sv =====
// valid/ready channel interfaces for the alarm table item and result beats
// no dependencies

interface at_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] flt_id;
  logic [2:0]  severity;

  modport source (output valid, mode, flt_id, severity, input ready);
  modport sink (input valid, mode, flt_id, severity, output ready);
endinterface

interface at_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        is_active;
  logic [31:0] raise_cnt;
  logic [4:0]  active_count;
  logic [2:0]  max_severity;
  logic        event_logged;
  logic [31:0] log_seq;

  modport source (output valid, status, is_active, raise_cnt, active_count,
                  max_severity, event_logged, log_seq, input ready);
  modport sink (input valid, status, is_active, raise_cnt, active_count,
                max_severity, event_logged, log_seq, output ready);
endinterface

// ===== sv/at_cell.sv =====
// one alarm slot: holds active bit, id, severity and raise count
// depends on at_pkg; passes the token to its right neighbor every cycle

module at_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [at_pkg::SLOT_W-1:0] slot_idx_i,
  input  at_pkg::tok_t             tok_i,
  output at_pkg::tok_t             tok_o
);

  logic                       active_q, active_d;
  logic [at_pkg::ID_BITS-1:0] id_q, id_d;
  logic [2:0]                 sev_q, sev_d;
  logic [31:0]                raises_q, raises_d;
  at_pkg::tok_t               tok_q, tok_d;
  logic                       apply;

  assign apply = tok_i.vld && (tok_i.phase == at_pkg::PH_APPLY);

  always_comb begin
    tok_d    = tok_i;
    active_d = active_q;
    id_d     = id_q;
    sev_d    = sev_q;
    raises_d = raises_q;
    if (tok_i.phase == at_pkg::PH_SEARCH) begin
      if (active_q && (id_q == tok_i.id) && !tok_d.hit) begin
        tok_d.hit     = 1'b1;
        tok_d.hit_idx = slot_idx_i;
      end
      if (!active_q && !tok_d.free_found) begin
        tok_d.free_found = 1'b1;
        tok_d.free_idx   = slot_idx_i;
      end
    end else begin
      if (tok_i.tgt == slot_idx_i) begin
        case (tok_i.op)
          at_pkg::OP_REFRESH: begin
            sev_d = tok_i.sev;
            if (raises_q != '1) raises_d = raises_q + 32'd1;
          end
          at_pkg::OP_NEW: begin
            active_d = 1'b1;
            id_d     = tok_i.id;
            sev_d    = tok_i.sev;
            raises_d = 32'd1;
          end
          at_pkg::OP_CLEAR: active_d = 1'b0;
          default: ;
        endcase
      end
      // aggregate over the post-update table
      if (active_d) begin
        tok_d.count = tok_d.count + at_pkg::CNT_W'(1);
        if (sev_d > tok_d.maxsev) tok_d.maxsev = sev_d;
        if ((id_d == tok_i.id) && !tok_d.hit) begin
          tok_d.hit    = 1'b1;
          tok_d.raises = raises_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      tok_q    <= '0;
    end else begin
      tok_q <= tok_d;
      if (apply) active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply) begin
      id_q     <= id_d;
      sev_q    <= sev_d;
      raises_q <= raises_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== sv/at_history.sv =====
// history ring and wrapping sequence counter of the alarm table
// depends on at_pkg; ring entries are write-only

module at_history (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [at_pkg::ID_BITS-1:0] id_i,
  input  logic [2:0]                 sev_i,
  output logic [31:0]                seq_o
);

  logic [50:0]               ring_mem [at_pkg::HISTORY_DEPTH];
  logic [at_pkg::HIST_W-1:0] head_q, head_d;
  logic [31:0]               ctr_q, ctr_d;
  logic [31:0]               id_ext;

  assign id_ext = 32'(id_i);
  assign ctr_d  = ctr_q + 32'd1;
  assign head_d = (head_q == at_pkg::HIST_W'(at_pkg::HISTORY_DEPTH - 1)) ?
                  '0 : head_q + at_pkg::HIST_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      ctr_q  <= '0;
    end else if (we_i) begin
      head_q <= head_d;
      ctr_q  <= ctr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) ring_mem[head_q] <= {ctr_q, sev_i, id_ext[15:0]};
  end

  assign seq_o = ctr_q;

endmodule

// ===== sv/alarm_table.sv =====
// alarm table top: sequencer, chain of slot cells, history ring, result register
// depends on at_pkg, at_if, at_cell, at_history
//
//   channel   dir  handshake      payload
//   item_i    in   valid/ready    mode, flt_id, severity
//   result_o  out  valid/ready    status .. log_seq, one beat per item
//
// from accept to result register, a search token and then an apply token each walk
// the cell chain, one cell per cycle; fin_q then takes the finished token and the
// done state loads the result into the output register.
// one item is in work at a time; a new item is accepted while a result waits.
// rst_ni clears the active bits, the token path, history head and counter.
// a stalled result only holds the finished item in its done state.

module alarm_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  at_in_if.sink       item_i,
  at_out_if.source    result_o
);

  at_pkg::state_e state_q, state_d;

  at_pkg::tok_t chain [at_pkg::ALARM_SLOTS+1];
  at_pkg::tok_t inj_q, inj_d;
  at_pkg::tok_t fin_q;
  at_pkg::tok_t tok_last;

  logic [1:0]                 mode_q;
  logic [at_pkg::ID_BITS-1:0] id_q;
  logic [2:0]                 sev_q;
  logic [1:0]                 status_q;
  logic                       logged_q;
  logic [31:0]                seq_q;

  logic        in_acc, decide, finish, load_out;
  logic        out_vld_q;
  logic [1:0]  out_status_q;
  logic        out_active_q;
  logic [31:0] out_raises_q;
  logic [4:0]  out_cnt_q;
  logic [2:0]  out_maxsev_q;
  logic        out_logged_q;
  logic [31:0] out_seq_q;

  // decision after the search pass
  at_pkg::op_e               dec_op;
  logic [at_pkg::SLOT_W-1:0] dec_tgt;
  logic [1:0]                dec_status;
  logic                      dec_log;
  logic [2:0]                dec_log_sev;
  logic [31:0]               hist_seq;

  assign tok_last = chain[at_pkg::ALARM_SLOTS];
  assign chain[0] = inj_q;

  for (genvar g = 0; g < at_pkg::ALARM_SLOTS; g++) begin : g_cell
    at_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .slot_idx_i (at_pkg::SLOT_W'(g)),
      .tok_i      (chain[g]),
      .tok_o      (chain[g+1])
    );
  end

  at_history u_history (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (decide && dec_log),
    .id_i   (id_q),
    .sev_i  (dec_log_sev),
    .seq_o  (hist_seq)
  );

  always_comb begin
    dec_op      = at_pkg::OP_NONE;
    dec_tgt     = '0;
    dec_status  = at_pkg::RS_OK;
    dec_log     = 1'b0;
    dec_log_sev = 3'd0;
    case (mode_q)
      at_pkg::MODE_RAISE: begin
        if ((sev_q == 3'd0) || (sev_q > at_pkg::SEV_MAX)) begin
          dec_status = at_pkg::RS_BAD;
        end else if (tok_last.hit) begin
          dec_op  = at_pkg::OP_REFRESH;
          dec_tgt = tok_last.hit_idx;
        end else if (tok_last.free_found) begin
          dec_op      = at_pkg::OP_NEW;
          dec_tgt     = tok_last.free_idx;
          dec_log     = 1'b1;
          dec_log_sev = sev_q;
        end else begin
          dec_status = at_pkg::RS_FULL;
        end
      end
      at_pkg::MODE_CLEAR: begin
        if (tok_last.hit) begin
          dec_op  = at_pkg::OP_CLEAR;
          dec_tgt = tok_last.hit_idx;
          dec_log = 1'b1;
        end else begin
          dec_status = at_pkg::RS_BAD;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      at_pkg::S_IDLE:   if (item_i.valid) state_d = at_pkg::S_SEARCH;
      at_pkg::S_SEARCH: if (tok_last.vld) state_d = at_pkg::S_APPLY;
      at_pkg::S_APPLY:  if (tok_last.vld) state_d = at_pkg::S_DONE;
      at_pkg::S_DONE:   if (!out_vld_q || result_o.ready) state_d = at_pkg::S_IDLE;
      default:          state_d = at_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    item_i.ready = 1'b0;
    decide       = 1'b0;
    finish       = 1'b0;
    load_out     = 1'b0;
    case (state_q)
      at_pkg::S_IDLE:   item_i.ready = 1'b1;
      at_pkg::S_SEARCH: decide = tok_last.vld;
      at_pkg::S_APPLY:  finish = tok_last.vld;
      at_pkg::S_DONE:   load_out = !out_vld_q || result_o.ready;
      default: ;
    endcase
  end

  assign in_acc = item_i.valid && item_i.ready;

  always_comb begin
    inj_d     = '0;
    inj_d.vld = 1'b0;
    if (in_acc) begin
      inj_d.vld   = 1'b1;
      inj_d.phase = at_pkg::PH_SEARCH;
      inj_d.id    = at_pkg::id_of(item_i.flt_id);
    end else if (decide) begin
      inj_d.vld   = 1'b1;
      inj_d.phase = at_pkg::PH_APPLY;
      inj_d.id    = id_q;
      inj_d.sev   = sev_q;
      inj_d.op    = dec_op;
      inj_d.tgt   = dec_tgt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= at_pkg::S_IDLE;
      inj_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inj_q   <= inj_d;
      if (load_out) out_vld_q <= 1'b1;
      else if (result_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= item_i.mode;
      id_q   <= at_pkg::id_of(item_i.flt_id);
      sev_q  <= item_i.severity;
    end
    if (decide) begin
      status_q <= dec_status;
      logged_q <= dec_log;
      seq_q    <= dec_log ? hist_seq : 32'd0;
    end
    if (finish) fin_q <= tok_last;
    if (load_out) begin
      out_status_q <= status_q;
      out_active_q <= fin_q.hit;
      out_raises_q <= fin_q.hit ? fin_q.raises : 32'd0;
      out_cnt_q    <= 5'(fin_q.count);
      out_maxsev_q <= fin_q.maxsev;
      out_logged_q <= logged_q;
      out_seq_q    <= seq_q;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.status       = out_status_q;
  assign result_o.is_active    = out_active_q;
  assign result_o.raise_cnt    = out_raises_q;
  assign result_o.active_count = out_cnt_q;
  assign result_o.max_severity = out_maxsev_q;
  assign result_o.event_logged = out_logged_q;
  assign result_o.log_seq      = out_seq_q;

  a_tok_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_last.vld |-> (state_q == at_pkg::S_SEARCH || state_q == at_pkg::S_APPLY))
    else $error("token left the chain outside a pass");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> (32'(tok_last.count) <= 32'(at_pkg::ALARM_SLOTS)))
    else $error("active count above slot count");

  a_log_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (decide && dec_log) |-> (dec_status == at_pkg::RS_OK))
    else $error("history written on a failed request");

  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_active_q) |-> (out_raises_q == 32'd0))
    else $error("raise count reported for an inactive id");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (decide && dec_log) |=> (hist_seq == $past(hist_seq) + 32'd1))
    else $error("sequence counter did not advance");

endmodule

// ===== sim/tb_alarm_table.sv =====
// self-checking bench for alarm_table: directed table walk, then random phases
// depends on at_pkg, at_if and the alarm_table rtl; a shadow table predicts each result

module tb_alarm_table;

  localparam int RUN_LIMIT    = 400000;
  localparam int PHASE_ITEMS  = 450;
  localparam int IDLE_PCT     = 18;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 2 * at_pkg::ALARM_SLOTS + 8;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [2:0] SEV_NONE  = 3'd0;
  localparam logic [2:0] SEV_WARN  = 3'd1;
  localparam logic [2:0] SEV_MINOR = 3'd2;
  localparam logic [2:0] SEV_MAJOR = 3'd3;
  localparam logic [2:0] SEV_CRIT  = 3'd4;
  localparam logic [2:0] SEV_TOP   = 3'd7;

  typedef struct packed {
    at_pkg::status_e status;
    logic            is_active;
    logic [31:0]     raise_cnt;
    logic [4:0]      active_count;
    logic [2:0]      max_severity;
    logic            event_logged;
    logic [31:0]     log_seq;
  } alarm_report_t;

  typedef struct {
    logic [1:0]    mode;
    logic [15:0]   flt_id;
    logic [2:0]    severity;
    bit            fixed;
    alarm_report_t report;
  } stim_row_t;

  logic clk;
  logic rst_n;

  at_in_if  item_if ();
  at_out_if res_if ();

  alarm_table dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_if),
    .result_o (res_if)
  );

  // shadow copy of the alarm slots and the sequence counter
  logic                       tbl_on   [at_pkg::ALARM_SLOTS];
  logic [at_pkg::ID_BITS-1:0] tbl_id   [at_pkg::ALARM_SLOTS];
  logic [2:0]                 tbl_sev  [at_pkg::ALARM_SLOTS];
  logic [31:0]                tbl_hits [at_pkg::ALARM_SLOTS];
  logic [31:0]                hist_seq;

  alarm_report_t reports_due[$];
  logic [15:0]   id_pool[$];

  int errors;
  int items_sent;
  int beats_seen;
  int n_bad;
  int n_full;
  int n_logged;
  int cycle_cnt;
  bit calm;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int lookup_slot(input logic [at_pkg::ID_BITS-1:0] id);
    for (int i = 0; i < at_pkg::ALARM_SLOTS; i++)
      if (tbl_on[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  // applies one item to the shadow table and returns the report it produces
  function automatic alarm_report_t table_update(input logic [1:0] m, input logic [15:0] f,
                                                 input logic [2:0] s);
    alarm_report_t r;
    logic [at_pkg::ID_BITS-1:0] id;
    int hit;
    int spare;
    r = '0;
    r.status = at_pkg::RS_OK;
    id = at_pkg::id_of(f);
    if (m == at_pkg::MODE_RAISE) begin
      if (s == SEV_NONE || s > at_pkg::SEV_MAX) begin
        r.status = at_pkg::RS_BAD;
      end else begin
        hit = lookup_slot(id);
        if (hit >= 0) begin
          tbl_sev[hit] = s;
          if (tbl_hits[hit] != 32'hFFFF_FFFF) tbl_hits[hit] = tbl_hits[hit] + 1;
        end else begin
          spare = -1;
          for (int i = at_pkg::ALARM_SLOTS - 1; i >= 0; i--)
            if (!tbl_on[i]) spare = i;
          if (spare < 0) begin
            r.status = at_pkg::RS_FULL;
          end else begin
            tbl_on[spare]   = 1'b1;
            tbl_id[spare]   = id;
            tbl_sev[spare]  = s;
            tbl_hits[spare] = 32'd1;
            r.event_logged  = 1'b1;
            r.log_seq       = hist_seq;
            hist_seq        = hist_seq + 1;
          end
        end
      end
    end else if (m == at_pkg::MODE_CLEAR) begin
      hit = lookup_slot(id);
      if (hit < 0) begin
        r.status = at_pkg::RS_BAD;
      end else begin
        tbl_on[hit]    = 1'b0;
        r.event_logged = 1'b1;
        r.log_seq      = hist_seq;
        hist_seq       = hist_seq + 1;
      end
    end
    for (int i = 0; i < at_pkg::ALARM_SLOTS; i++) begin
      if (tbl_on[i]) begin
        r.active_count = r.active_count + 5'd1;
        if (tbl_sev[i] > r.max_severity) r.max_severity = tbl_sev[i];
      end
    end
    hit = lookup_slot(id);
    if (hit >= 0) begin
      r.is_active = 1'b1;
      r.raise_cnt = tbl_hits[hit];
    end
    return r;
  endfunction

  function automatic stim_row_t plain_row(input logic [1:0] m, input logic [15:0] f,
                                          input logic [2:0] s);
    stim_row_t row;
    row.mode     = m;
    row.flt_id   = f;
    row.severity = s;
    row.fixed    = 1'b0;
    row.report   = '0;
    return row;
  endfunction

  function automatic stim_row_t fixed_row(input logic [1:0] m, input logic [15:0] f,
                                          input logic [2:0] s, input at_pkg::status_e st,
                                          input int act, input logic [31:0] cnt,
                                          input int acnt, input logic [2:0] ms,
                                          input int lg, input logic [31:0] seq);
    stim_row_t row;
    row = plain_row(m, f, s);
    row.fixed = 1'b1;
    row.report.status       = st;
    row.report.is_active    = 1'(act);
    row.report.raise_cnt    = cnt;
    row.report.active_count = 5'(acnt);
    row.report.max_severity = ms;
    row.report.event_logged = 1'(lg);
    row.report.log_seq      = seq;
    return row;
  endfunction

  function automatic string report_str(input alarm_report_t r);
    return $sformatf("st=%0d act=%0d cnt=%0d acnt=%0d maxsev=%0d log=%0d seq=%0d",
                     r.status, r.is_active, r.raise_cnt, r.active_count,
                     r.max_severity, r.event_logged, r.log_seq);
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endtask

  // offers one item beat, with random idle cycles ahead of it
  task automatic send_item(input logic [1:0] m, input logic [15:0] f, input logic [2:0] s,
                           input bit fixed, input alarm_report_t rep);
    alarm_report_t r;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      item_if.valid    <= 1'b0;
      item_if.mode     <= 2'($urandom_range(0, 3));
      item_if.flt_id   <= 16'($urandom);
      item_if.severity <= 3'($urandom_range(0, 7));
      @(negedge clk);
    end
    item_if.valid    <= 1'b1;
    item_if.mode     <= m;
    item_if.flt_id   <= f;
    item_if.severity <= s;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    r = table_update(m, f, s);
    reports_due.push_back(fixed ? rep : r);
    items_sent++;
    @(negedge clk);
  endtask

  // stops offering until every outstanding report has come back
  task automatic drain_reports();
    item_if.valid <= 1'b0;
    @(negedge clk);
    while (reports_due.size() != 0) @(negedge clk);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
      end else begin
        res_if.ready <= (calm || $urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    alarm_report_t got;
    alarm_report_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.status       = at_pkg::status_e'(res_if.status);
      got.is_active    = res_if.is_active;
      got.raise_cnt    = res_if.raise_cnt;
      got.active_count = res_if.active_count;
      got.max_severity = res_if.max_severity;
      got.event_logged = res_if.event_logged;
      got.log_seq      = res_if.log_seq;
      beats_seen++;
      if (got.status == at_pkg::RS_BAD) n_bad++;
      if (got.status == at_pkg::RS_FULL) n_full++;
      if (got.event_logged) n_logged++;
      if (reports_due.size() == 0) begin
        flag_error($sformatf("result beat %0d arrived with no item waiting: %s",
                             beats_seen, report_str(got)));
      end else begin
        want = reports_due.pop_front();
        if (got.status !== want.status || got.is_active !== want.is_active ||
            got.raise_cnt !== want.raise_cnt ||
            got.active_count !== want.active_count ||
            got.max_severity !== want.max_severity ||
            got.event_logged !== want.event_logged ||
            got.log_seq !== want.log_seq)
          flag_error($sformatf("beat %0d expected %s got %s", beats_seen,
                               report_str(want), report_str(got)));
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("run stopped after %0d cycles with %0d reports outstanding",
             cycle_cnt, reports_due.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    stim_row_t dir_rows[$];
    int roll;
    int pool_n;
    int raise_pct;
    int clear_pct;
    logic [1:0]  m;
    logic [15:0] f;
    logic [2:0]  s;

    errors     = 0;
    items_sent = 0;
    beats_seen = 0;
    n_bad      = 0;
    n_full     = 0;
    n_logged   = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    for (int i = 0; i < at_pkg::ALARM_SLOTS; i++) begin
      tbl_on[i]   = 1'b0;
      tbl_id[i]   = '0;
      tbl_sev[i]  = '0;
      tbl_hits[i] = '0;
    end
    hist_seq = '0;

    item_if.valid    = 1'b0;
    item_if.mode     = at_pkg::MODE_QUERY;
    item_if.flt_id   = '0;
    item_if.severity = SEV_NONE;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, rejected requests, then first raises and a refresh
    dir_rows.push_back(fixed_row(at_pkg::MODE_QUERY, 16'h0000, SEV_NONE, at_pkg::RS_OK,
                                 0, 0, 0, SEV_NONE, 0, 0));
    dir_rows.push_back(fixed_row(at_pkg::MODE_RAISE, 16'h0000, SEV_NONE, at_pkg::RS_BAD,
                                 0, 0, 0, SEV_NONE, 0, 0));
    dir_rows.push_back(fixed_row(at_pkg::MODE_RAISE, 16'hFFFF, SEV_TOP, at_pkg::RS_BAD,
                                 0, 0, 0, SEV_NONE, 0, 0));
    dir_rows.push_back(fixed_row(at_pkg::MODE_CLEAR, 16'h1234, SEV_WARN, at_pkg::RS_BAD,
                                 0, 0, 0, SEV_NONE, 0, 0));
    dir_rows.push_back(fixed_row(MODE_SPARE, 16'hFFFF, SEV_TOP, at_pkg::RS_OK,
                                 0, 0, 0, SEV_NONE, 0, 0));
    dir_rows.push_back(fixed_row(at_pkg::MODE_RAISE, 16'hFFFF, SEV_CRIT, at_pkg::RS_OK,
                                 1, 1, 1, SEV_CRIT, 1, 0));
    dir_rows.push_back(fixed_row(at_pkg::MODE_RAISE, 16'h0000, SEV_WARN, at_pkg::RS_OK,
                                 1, 1, 2, SEV_CRIT, 1, 1));
    dir_rows.push_back(fixed_row(at_pkg::MODE_RAISE, 16'hFFFF, SEV_MINOR, at_pkg::RS_OK,
                                 1, 2, 2, SEV_MINOR, 0, 0));
    // fill every slot, then a raise that finds no room, a clear and a raise with a bad severity
    for (int k = 0; k < at_pkg::ALARM_SLOTS - 2; k++)
      dir_rows.push_back(plain_row(at_pkg::MODE_RAISE, 16'(1 << k), 3'(k % 4 + 1)));
    dir_rows.push_back(plain_row(at_pkg::MODE_RAISE, 16'h8000, SEV_MAJOR));
    dir_rows.push_back(plain_row(at_pkg::MODE_CLEAR, 16'hFFFF, SEV_NONE));
    dir_rows.push_back(plain_row(at_pkg::MODE_RAISE, 16'hAAAA, 3'd5));

    foreach (dir_rows[i])
      send_item(dir_rows[i].mode, dir_rows[i].flt_id, dir_rows[i].severity,
                dir_rows[i].fixed, dir_rows[i].report);
    drain_reports();

    // random phases: mixed, fill-heavy, drain-heavy, tight pool with many refreshes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin pool_n = 12; raise_pct = 50; clear_pct = 30; end
        1: begin pool_n = 40; raise_pct = 70; clear_pct = 15; end
        2: begin pool_n = 40; raise_pct = 20; clear_pct = 60; end
        default: begin pool_n = 6; raise_pct = 50; clear_pct = 35; end
      endcase
      // the drain phase reuses the fill phase ids so its clears hit
      if (ph != 2) begin
        id_pool.delete();
        for (int k = 0; k < pool_n; k++) id_pool.push_back(16'($urandom_range(0, 65535)));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        calm = (items_sent >= 700 && items_sent < 1000);
        if (items_sent == 1300) hold_req = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          m = 2'($urandom_range(0, 3));
          f = 16'($urandom);
          s = 3'($urandom_range(0, 7));
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < raise_pct) m = at_pkg::MODE_RAISE;
          else if (roll < raise_pct + clear_pct) m = at_pkg::MODE_CLEAR;
          else m = at_pkg::MODE_QUERY;
          f = ($urandom_range(0, 9) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, pool_n - 1)];
          s = 3'($urandom_range(SEV_WARN, SEV_CRIT));
        end
        send_item(m, f, s, 1'b0, '0);
      end
      calm = 1'b0;
      drain_reports();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (reports_due.size() != 0)
      flag_error($sformatf("%0d reports never arrived", reports_due.size()));

    $display("covered %0d items and %0d result beats in %0d cycles",
             items_sent, beats_seen, cycle_cnt);
    $display("history writes %0d, bad requests %0d, table full %0d, errors %0d",
             n_logged, n_bad, n_full, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
